### hw/rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// shared types and constants for the lru key-value cache
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0]         CAP_RESET  = 5'd16;
  localparam logic                     MODE_GET   = 1'b0;
  localparam logic                     MODE_PUT   = 1'b1;
  localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;
  localparam logic signed [DATA_W-1:0] PUT_VALUE  = 32'sd0;

  typedef struct packed {
    logic                     mode;
    logic signed [KEY_W-1:0]  lookup_key;
    logic signed [DATA_W-1:0] write_value;
  } lkv_req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
  } lkv_rsp_t;

endpackage

### hw/rtl/lkv_store.sv
// ----------------------------------------------------------------------------
// lkv_store
// entry registers with parallel key match, recency ranks and replacement
// ----------------------------------------------------------------------------
module lkv_store (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [lkv_pkg::CAP_W-1:0]        cfg_data,
  input  logic                             fire,
  input  lkv_pkg::lkv_req_t                req,
  output lkv_pkg::lkv_rsp_t                rsp
);

  logic [lkv_pkg::CAP_W-1:0]         capacity;
  logic [lkv_pkg::ENTRIES-1:0]       valid;
  logic [lkv_pkg::KEY_W-1:0]         key_mem  [lkv_pkg::ENTRIES];
  logic [lkv_pkg::DATA_W-1:0]        value_mem[lkv_pkg::ENTRIES];
  logic [lkv_pkg::RANK_W-1:0]        rank     [lkv_pkg::ENTRIES];
  logic [lkv_pkg::CNT_W-1:0]         live_count;

  logic [lkv_pkg::ENTRIES-1:0]       match;
  logic [lkv_pkg::ENTRIES-1:0]       lru_match;
  logic                              found;
  logic [lkv_pkg::IDX_W-1:0]         found_idx;
  logic [lkv_pkg::IDX_W-1:0]         victim_idx;
  logic [lkv_pkg::IDX_W-1:0]         free_idx;
  logic [lkv_pkg::IDX_W-1:0]         slot;
  logic [lkv_pkg::RANK_W-1:0]        found_rank;
  logic [lkv_pkg::RANK_W-1:0]        lru_rank;
  logic [lkv_pkg::CNT_W-1:0]         eff_capacity;
  logic                              full;
  logic                              is_put;

  // effective capacity: zero acts as one, saturate at the entry count
  always_comb begin
    if (capacity == '0) begin
      eff_capacity = lkv_pkg::CNT_W'(1);
    end else if (32'(capacity) > 32'(lkv_pkg::ENTRIES)) begin
      eff_capacity = lkv_pkg::CNT_W'(lkv_pkg::ENTRIES);
    end else begin
      eff_capacity = lkv_pkg::CNT_W'(capacity);
    end
  end

  assign lru_rank = lkv_pkg::RANK_W'(live_count - 1'b1);
  assign full     = (live_count >= eff_capacity);
  assign is_put   = (req.mode == lkv_pkg::MODE_PUT);

  always_comb begin
    for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
      match[i]     = valid[i] && (key_mem[i] == req.lookup_key);
      lru_match[i] = valid[i] && (rank[i] == lru_rank);
    end
  end

  assign found = |match;

  always_comb begin
    found_idx  = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_idx = lkv_pkg::IDX_W'(i);
      end
      if (lru_match[i]) begin
        victim_idx = lkv_pkg::IDX_W'(i);
      end
      if (!valid[i]) begin
        free_idx = lkv_pkg::IDX_W'(i);
      end
    end
  end

  assign found_rank = rank[found_idx];
  assign slot       = full ? victim_idx : free_idx;

  always_comb begin
    rsp.hit     = found;
    rsp.evicted = is_put && !found && full;
    if (is_put) begin
      rsp.read_value = lkv_pkg::PUT_VALUE;
    end else if (found) begin
      rsp.read_value = value_mem[found_idx];
    end else begin
      rsp.read_value = lkv_pkg::MISS_VALUE;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= lkv_pkg::CAP_RESET;
      valid      <= '0;
      live_count <= '0;
    end else begin
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      if (fire && is_put && !found) begin
        valid[slot] <= 1'b1;
        if (!full) begin
          live_count <= live_count + 1'b1;
        end
      end
    end
  end

  // entry payload and ranks
  always_ff @(posedge clk) begin
    if (fire) begin
      if (found) begin
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
          if (valid[i] && (rank[i] < found_rank)) begin
            rank[i] <= lkv_pkg::RANK_W'(rank[i] + 1'b1);
          end
        end
        rank[found_idx] <= '0;
        if (is_put) begin
          value_mem[found_idx] <= req.write_value;
        end
      end else if (is_put) begin
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
          if (valid[i]) begin
            rank[i] <= lkv_pkg::RANK_W'(rank[i] + 1'b1);
          end
        end
        rank[slot]      <= '0;
        key_mem[slot]   <= req.lookup_key;
        value_mem[slot] <= req.write_value;
      end
    end
  end

endmodule

### hw/rtl/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// fully associative key-value cache with least-recently-used replacement
//
//   channel   valid      stall      payload              direction
//   request   in_valid   in_stall   in_word  (lkv_req_t)  into block
//   response  out_valid  out_stall  out_word (lkv_rsp_t)  out of block
//   config    cfg_write  -          cfg_data (5 bits)     into block
//
// one word per cycle sustained while the response is not stalled; a word
// waits in the input register while the parallel key compare and rank
// update run, then sits in the output register that drives out_valid
// synchronous reset empties the cache and sets capacity to 16
// a stalled response holds; the input register keeps taking words while
// the output register is free or being drained in the same cycle
// ----------------------------------------------------------------------------
module lru_key_value_cache_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lkv_pkg::lkv_req_t         in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lkv_pkg::lkv_rsp_t         out_word
);

  lkv_pkg::lkv_req_t req;
  logic              req_valid;
  lkv_pkg::lkv_rsp_t rsp;
  logic              advance;
  logic              accept;

  assign advance  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !advance;
  assign accept   = in_valid && !in_stall;

  lkv_store u_store (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .req       (req),
    .rsp       (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        req_valid <= 1'b1;
      end else if (advance) begin
        req_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= in_word;
    end
    if (advance) begin
      out_word <= rsp;
    end
  end

endmodule

### hw/rtl/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker
// port-level checks for the lru key-value cache
// ----------------------------------------------------------------------------
module lkv_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input lkv_pkg::lkv_rsp_t         out_word
);

  // stalled response word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("response word changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("response valid after reset");

  // an empty output register never back-pressures the request side
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("request stalled with output register free");

  // an eviction only happens on a put miss, which reads as zero
  a_evict_is_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.evicted |->
      !out_word.hit && (out_word.read_value == lkv_pkg::PUT_VALUE))
    else $error("eviction reported on a hit or with a read value");

endmodule

bind lru_key_value_cache_top lkv_checker u_lkv_checker (.*);
